/* hdl/gytc_pkg.sv */
package gytc_pkg;

  localparam int unsigned MulMcW   = 31;
  localparam int unsigned MulMplW  = 9;
  localparam int unsigned MulProdW = MulMcW + MulMplW;
  localparam int unsigned MulCntW  = 4;
  localparam logic [MulCntW-1:0] MulSteps = 4'd9;

  localparam int unsigned DivDvdW = 38;
  localparam int unsigned DivDvsW = 30;
  localparam int unsigned DivCntW = 6;
  localparam logic [DivCntW-1:0] DivSteps = 6'd38;

  localparam logic [30:0] FullTurnFine = 31'd1440000000;
  localparam logic signed [32:0] FullTurnS = 33'sd1440000000;
  localparam logic signed [32:0] HalfTurnS = 33'sd720000000;
  localparam logic signed [32:0] NegHalfTurnS = -33'sd720000000;
  localparam logic [DivDvsW-1:0] FinePerMdeg = 30'd4000;
  localparam logic [16:0] TimerMax = 17'h1FFFF;

  localparam logic [29:0] AngleFineRst = 30'd360000000;
  localparam logic [27:0] TolFineRst   = 28'd12000000;
  localparam logic [28:0] BandFineRst  = 29'd80000000;
  localparam logic [7:0]  FullSpeedRst = 8'd255;
  localparam logic [7:0]  FloorRst     = 8'd30;
  localparam logic [15:0] TimeoutRst   = 16'd3000;
  localparam logic [15:0] BiasRst      = 16'd500;

  localparam logic [2:0] CfgTurnAngle = 3'd0;
  localparam logic [2:0] CfgTolerance = 3'd1;
  localparam logic [2:0] CfgRampBand  = 3'd2;
  localparam logic [2:0] CfgFullSpeed = 3'd3;
  localparam logic [2:0] CfgFloor     = 3'd4;
  localparam logic [2:0] CfgTimeout   = 3'd5;
  localparam logic [2:0] CfgBias      = 3'd6;

  localparam logic [1:0] CmdNone    = 2'd0;
  localparam logic [1:0] CmdStop    = 2'd1;
  localparam logic [1:0] CmdRotUp   = 2'd2;
  localparam logic [1:0] CmdRotDown = 2'd3;

  localparam logic [1:0] StatusIdle    = 2'd0;
  localparam logic [1:0] StatusTurning = 2'd1;
  localparam logic [1:0] StatusDone    = 2'd2;
  localparam logic [1:0] StatusTimeout = 2'd3;

  typedef struct packed {
    logic               start;
    logic [MulMcW-1:0]  mcand;
    logic [MulMplW-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [MulProdW-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DivDvdW-1:0] dividend;
    logic [DivDvsW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivDvdW-1:0] quotient;
  } div_rsp_t;

  // Millidegrees to fine units, 4000 = 4096 - 64 - 32.
  function automatic logic [29:0] mdeg_to_fine(input logic [17:0] x);
    return {x, 12'b0} - 30'({x, 6'b0}) - 30'({x, 5'b0});
  endfunction

endpackage

/* hdl/gyro_yaw_turn_controller_top.sv */
// Channel  Direction  Signals                          Contents
// s_axis   in         tvalid, tready, tdata[39:0]      one control period
// m_axis   out        tvalid, tready, tdata[31:0]      one motor command
// cfg      in         cfg_we_i, cfg_index_i, cfg_wdata_i  register write, no wait
//
// Each item runs the bit-serial multiplier (two products of 9 steps) and the
// bit-serial divider (two quotients of 38 steps), one after the other.
// Reset clears the yaw, the turn state and the registers to their defaults.
// A result waiting in the output register holds the block before it loads the
// next one; input is not taken until the block has returned to idle.
module gyro_yaw_turn_controller_top import gytc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // gyro_raw[15:0], elapsed_ms[31:16], start_req[32], turn_positive[33], zero
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_cmd[1:0], motor_speed[9:2], turn_status[11:10], yaw_mdeg[30:12], zero
  output logic [31:0] m_axis_tdata,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_wdata_i
);

  typedef enum logic [12:0] {
    StIdle   = 13'b0000000000001,
    StRate   = 13'b0000000000010,
    StMul1   = 13'b0000000000100,
    StInteg  = 13'b0000000001000,
    StStart  = 13'b0000000010000,
    StErr    = 13'b0000000100000,
    StAbs    = 13'b0000001000000,
    StCmp    = 13'b0000010000000,
    StMul2   = 13'b0000100000000,
    StDiv1   = 13'b0001000000000,
    StDiv2Go = 13'b0010000000000,
    StDiv2   = 13'b0100000000000,
    StDone   = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [29:0] angle_fine_q;
  logic [27:0] tol_fine_q;
  logic [28:0] band_fine_q;
  logic [7:0]  full_q;
  logic [7:0]  floor_q;
  logic [15:0] timeout_q;
  logic [15:0] bias_q;

  logic [30:0] yaw_q, yaw_d;
  logic [30:0] target_q, target_d;
  logic        sense_q, sense_d;
  logic        active_q, active_d;
  logic [16:0] timer_q, timer_d;
  logic        new_q, new_d;
  logic        out_valid_q, out_valid_d;

  logic [15:0] gyro_q;
  logic [15:0] elapsed_q;
  logic        start_q;
  logic        pos_q;
  logic signed [32:0] err_q;
  logic [29:0] aerr_q;
  logic        done_hit_q;
  logic        tmo_q;
  logic        band_hit_q;
  logic [7:0]  speed_q;
  logic [18:0] yaw_mdeg_q;
  logic [1:0]  out_cmd_q;
  logic [7:0]  out_speed_q;
  logic [1:0]  out_status_q;
  logic [18:0] out_yaw_q;

  logic [29:0] cfg_fine;
  logic [29:0] cfg_tol_fine;
  logic [29:0] cfg_band_fine;
  logic [21:0] gyro_ext;
  logic [21:0] rate4;
  logic [8:0]  dt;
  logic signed [32:0] integ_sum;
  logic signed [32:0] delta;
  logic signed [32:0] target_sum;
  logic signed [32:0] diff;
  logic signed [32:0] err_adj;
  logic [32:0] err_neg;
  logic [17:0] timer_sum;
  logic [16:0] timer_sat;
  logic [7:0]  quot8;
  logic        out_load;
  logic [1:0]  cmd_d;
  logic [7:0]  spd_d;
  logic [1:0]  status_d;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  function automatic logic [30:0] wrap_fine(input logic signed [32:0] v);
    logic signed [32:0] r;
    r = v;
    if (v < 33'sd0) begin
      r = v + FullTurnS;
    end else if (v >= FullTurnS) begin
      r = v - FullTurnS;
    end
    return r[30:0];
  endfunction

  gytc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  gytc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign cfg_fine      = mdeg_to_fine(cfg_wdata_i);
  assign cfg_tol_fine  = mdeg_to_fine({2'b00, cfg_wdata_i[15:0]});
  assign cfg_band_fine = mdeg_to_fine({1'b0, cfg_wdata_i[16:0]});

  // Rate in quarter millidegrees per second: gyro * 35 - bias * 4.
  assign gyro_ext = {{6{gyro_q[15]}}, gyro_q};
  assign rate4 = {gyro_ext[16:0], 5'b0} + {gyro_ext[20:0], 1'b0} + gyro_ext
               - {{4{bias_q[15]}}, bias_q, 2'b00};
  assign dt = (elapsed_q == 16'd0 || elapsed_q > 16'd500) ? 9'd10 : elapsed_q[8:0];

  assign integ_sum  = $signed({2'b00, yaw_q}) + $signed(mul_rsp.product[32:0]);
  assign delta      = $signed({3'b000, angle_fine_q});
  assign target_sum = pos_q ? ($signed({2'b00, yaw_q}) + delta)
                            : ($signed({2'b00, yaw_q}) - delta);
  assign diff       = $signed({2'b00, target_q}) - $signed({2'b00, yaw_q});
  assign err_neg    = 33'd0 - err_q;
  assign timer_sum  = {1'b0, timer_q} + {2'b00, elapsed_q};
  assign timer_sat  = timer_sum[17] ? TimerMax : timer_sum[16:0];
  assign quot8      = div_rsp.quotient[7:0];
  assign out_load   = !out_valid_q || m_axis_tready;

  always_comb begin
    err_adj = diff;
    if (diff > HalfTurnS) begin
      err_adj = diff - FullTurnS;
    end else if (diff < NegHalfTurnS) begin
      err_adj = diff + FullTurnS;
    end
  end

  always_comb begin
    mul_req.start  = 1'b0;
    mul_req.mcand  = {1'b0, aerr_q};
    mul_req.mplier = {1'b0, full_q};
    if (state_q == StRate) begin
      mul_req.start  = 1'b1;
      mul_req.mcand  = {{9{rate4[21]}}, rate4};
      mul_req.mplier = dt;
    end else if (state_q == StCmp) begin
      mul_req.start = 1'b1;
    end
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = mul_rsp.product[DivDvdW-1:0];
    div_req.divisor  = {1'b0, band_fine_q};
    if (state_q == StMul2) begin
      div_req.start = mul_rsp.done;
    end else if (state_q == StDiv2Go) begin
      div_req.start    = 1'b1;
      div_req.dividend = {7'b0, yaw_q};
      div_req.divisor  = FinePerMdeg;
    end
  end

  always_comb begin
    cmd_d    = CmdNone;
    spd_d    = '0;
    status_d = StatusIdle;
    if (active_q) begin
      if (done_hit_q) begin
        cmd_d    = CmdStop;
        status_d = StatusDone;
      end else if (tmo_q) begin
        cmd_d    = CmdStop;
        status_d = StatusTimeout;
      end else begin
        cmd_d    = sense_q ? CmdRotUp : CmdRotDown;
        spd_d    = speed_q;
        status_d = StatusTurning;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    yaw_d       = yaw_q;
    target_d    = target_q;
    sense_d     = sense_q;
    active_d    = active_q;
    timer_d     = timer_q;
    new_d       = new_q;
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          state_d = StRate;
        end
      end
      StRate: begin
        state_d = StMul1;
      end
      StMul1: begin
        if (mul_rsp.done) begin
          state_d = StInteg;
        end
      end
      StInteg: begin
        yaw_d = wrap_fine(integ_sum);
        if (active_q) begin
          timer_d = timer_sat;
        end
        state_d = StStart;
      end
      StStart: begin
        new_d = 1'b0;
        if (start_q && !active_q) begin
          target_d = wrap_fine(target_sum);
          active_d = 1'b1;
          timer_d  = '0;
          new_d    = 1'b1;
        end
        state_d = StErr;
      end
      StErr: begin
        state_d = StAbs;
      end
      StAbs: begin
        if (new_q) begin
          sense_d = ~err_q[32];
        end
        state_d = StCmp;
      end
      StCmp: begin
        state_d = StMul2;
      end
      StMul2: begin
        if (mul_rsp.done) begin
          state_d = StDiv1;
        end
      end
      StDiv1: begin
        if (div_rsp.done) begin
          state_d = StDiv2Go;
        end
      end
      StDiv2Go: begin
        state_d = StDiv2;
      end
      StDiv2: begin
        if (div_rsp.done) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (active_q && (done_hit_q || tmo_q)) begin
            active_d = 1'b0;
          end
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      yaw_q        <= '0;
      target_q     <= '0;
      sense_q      <= 1'b0;
      active_q     <= 1'b0;
      timer_q      <= '0;
      new_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      angle_fine_q <= AngleFineRst;
      tol_fine_q   <= TolFineRst;
      band_fine_q  <= BandFineRst;
      full_q       <= FullSpeedRst;
      floor_q      <= FloorRst;
      timeout_q    <= TimeoutRst;
      bias_q       <= BiasRst;
    end else begin
      state_q     <= state_d;
      yaw_q       <= yaw_d;
      target_q    <= target_d;
      sense_q     <= sense_d;
      active_q    <= active_d;
      timer_q     <= timer_d;
      new_q       <= new_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTurnAngle: angle_fine_q <= cfg_fine;
          CfgTolerance: tol_fine_q   <= cfg_tol_fine[27:0];
          CfgRampBand:  band_fine_q  <= cfg_band_fine[28:0];
          CfgFullSpeed: full_q       <= cfg_wdata_i[7:0];
          CfgFloor:     floor_q      <= cfg_wdata_i[7:0];
          CfgTimeout:   timeout_q    <= cfg_wdata_i[15:0];
          CfgBias:      bias_q       <= cfg_wdata_i[15:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Tolerance and band are compared in fine units, so they only need an
  // upper bound rather than a conversion of the error back to millidegrees.
  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && s_axis_tvalid) begin
      gyro_q    <= s_axis_tdata[15:0];
      elapsed_q <= s_axis_tdata[31:16];
      start_q   <= s_axis_tdata[32];
      pos_q     <= s_axis_tdata[33];
    end
    if (state_q == StErr) begin
      err_q <= err_adj;
    end
    if (state_q == StAbs) begin
      aerr_q <= err_q[32] ? err_neg[29:0] : err_q[29:0];
    end
    if (state_q == StCmp) begin
      done_hit_q <= aerr_q <= {2'b00, tol_fine_q};
      tmo_q      <= timer_q > {1'b0, timeout_q};
      band_hit_q <= (band_fine_q != '0) && (aerr_q < {1'b0, band_fine_q});
    end
    if (state_q == StDiv1 && div_rsp.done) begin
      speed_q <= band_hit_q ? ((quot8 < floor_q) ? floor_q : quot8) : full_q;
    end
    if (state_q == StDiv2 && div_rsp.done) begin
      yaw_mdeg_q <= div_rsp.quotient[18:0];
    end
    if (state_q == StDone && out_load) begin
      out_cmd_q    <= cmd_d;
      out_speed_q  <= spd_d;
      out_status_q <= status_d;
      out_yaw_q    <= yaw_mdeg_q;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_yaw_q, out_status_q, out_speed_q, out_cmd_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_q < FullTurnFine) && (target_q < FullTurnFine))
    else $error("Yaw or target has left the full turn range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_rsp.busy && div_rsp.busy))
    else $error("Multiplier and divider are busy at the same time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_cmd_q == CmdNone || out_cmd_q == CmdStop)) |-> (out_speed_q == 8'd0))
    else $error("A non-rotate result carries a speed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_cmd_q == CmdNone) == (out_status_q == StatusIdle)))
    else $error("Command and status disagree about an idle result.");

endmodule

/* hdl/gytc_mul.sv */
module gytc_mul import gytc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [MulCntW-1:0]  cnt_q, cnt_d;
  logic [MulProdW-1:0] acc_q, acc_d;
  logic [MulProdW-1:0] mc_q, mc_d;
  logic [MulMplW-1:0]  mp_q, mp_d;

  // Shift-add over one multiplier bit per cycle; the multiplicand is signed.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    if (busy_q) begin
      if (mp_q[0]) begin
        acc_d = acc_q + mc_q;
      end
      mc_d  = {mc_q[MulProdW-2:0], 1'b0};
      mp_d  = {1'b0, mp_q[MulMplW-1:1]};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = MulSteps;
      acc_d  = '0;
      mc_d   = {{(MulProdW-MulMcW){req_i.mcand[MulMcW-1]}}, req_i.mcand};
      mp_d   = req_i.mplier;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

/* hdl/gytc_div.sv */
module gytc_div import gytc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDvsW-1:0] rem_q, rem_d;
  logic [DivDvsW-1:0] dvs_q, dvs_d;
  logic [DivDvdW-1:0] dvd_q, dvd_d;
  logic [DivDvsW:0]   rem_sh;
  logic [DivDvsW:0]   rem_sub;
  logic               fits;

  // Restoring division, one quotient bit per cycle. The dividend register
  // fills up with quotient bits from the bottom as it shifts out.
  assign rem_sh  = {rem_q, dvd_q[DivDvdW-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    dvd_d  = dvd_q;
    if (busy_q) begin
      rem_d = fits ? rem_sub[DivDvsW-1:0] : rem_sh[DivDvsW-1:0];
      dvd_d = {dvd_q[DivDvdW-2:0], fits};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivSteps;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      dvd_d  = req_i.dividend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dvd_q <= dvd_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import gytc_pkg::*;

  localparam longint FullTurn     = 64'sd1440000000;
  localparam longint HalfTurn     = 64'sd720000000;
  localparam longint FinePerMdegL = 64'sd4000;
  localparam longint TimerCap     = 64'sd131071;
  localparam int     StallLimit   = 5000;
  localparam int     SettleCycles = 200;
  localparam int     PhaseItems   = 84;
  localparam int     NumSettings  = 7;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  speed;
    logic [1:0]  status;
    logic [18:0] yaw;
  } motor_result_t;

  typedef struct packed {
    logic signed [15:0] gyro;
    logic [15:0]        elapsed;
    logic               start;
    logic               positive;
    logic               typed;
    motor_result_t      res;
  } stim_row_t;

  typedef struct packed {
    logic [17:0] angle;
    logic [15:0] tol;
    logic [16:0] band;
    logic [7:0]  full;
    logic [7:0]  floor;
    logic [15:0] timeout;
    logic [15:0] bias;
  } ctrl_setting_t;

  localparam motor_result_t NoTyped = '0;

  localparam stim_row_t DirectedRows [19] = '{
    '{16'sd0, 16'd10, 1'b0, 1'b0, 1'b1, '{CmdNone, 8'd0, StatusIdle, 19'd359995}},
    '{16'sd0, 16'd10, 1'b1, 1'b1, 1'b1, '{CmdRotUp, 8'd255, StatusTurning, 19'd359990}},
    '{16'sd32767, 16'd500, 1'b0, 1'b0, 1'b0, NoTyped},
    '{-16'sd32768, 16'd501, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd0, 16'd0, 1'b1, 1'b0, 1'b0, NoTyped},
    '{16'sd100, 16'd65535, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd0, 16'd10, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd18343, 16'd500, 1'b1, 1'b1, 1'b0, NoTyped},
    '{16'sd18343, 16'd500, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd0, 16'd10, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd8000, 16'd500, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd0, 16'd65535, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'sd20629, 16'd500, 1'b1, 1'b1, 1'b0, NoTyped},
    '{16'sd20629, 16'd500, 1'b0, 1'b0, 1'b0, NoTyped},
    '{-16'sd20514, 16'd500, 1'b1, 1'b0, 1'b0, NoTyped},
    '{-16'sd20514, 16'd500, 1'b0, 1'b0, 1'b0, NoTyped},
    '{16'h5555, 16'hAAAA, 1'b1, 1'b1, 1'b0, NoTyped},
    '{16'hAAAA, 16'h5555, 1'b1, 1'b0, 1'b0, NoTyped},
    '{16'hFFFF, 16'd1, 1'b0, 1'b0, 1'b0, NoTyped}
  };

  localparam ctrl_setting_t Settings [NumSettings] = '{
    '{18'd90000, 16'd3000, 17'd20000, 8'd255, 8'd30, 16'd3000, 16'd500},
    '{18'd1000, 16'd0, 17'd1000, 8'd0, 8'd0, 16'd1, 16'h8000},
    '{18'd179000, 16'd45000, 17'd90000, 8'd255, 8'd255, 16'd65535, 16'h7FFF},
    '{18'd200000, 16'd2000, 17'd0, 8'd200, 8'd40, 16'd5000, 16'hFE0C},
    '{18'd45000, 16'd500, 17'd60000, 8'd100, 8'd150, 16'd2000, 16'd0},
    '{18'd262143, 16'd65535, 17'd131071, 8'd255, 8'd0, 16'd0, 16'hFFFF},
    '{18'd30000, 16'd1500, 17'd15000, 8'd180, 8'd20, 16'd4000, 16'd250}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [17:0] cfg_wdata_i;

  logic [17:0]        cfg_turn_angle;
  logic [15:0]        cfg_tolerance;
  logic [16:0]        cfg_ramp_band;
  logic [7:0]         cfg_full_speed;
  logic [7:0]         cfg_floor_speed;
  logic [15:0]        cfg_timeout;
  logic signed [15:0] cfg_bias;

  longint track_yaw;
  longint track_target;
  longint track_timer;
  bit     track_sense;
  bit     track_active;

  motor_result_t pending_results [$];
  int            fail_count = 0;
  bit            idling_on = 1'b1;

  gyro_yaw_turn_controller_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint wrap_turn(input longint v);
    longint r;
    r = v % FullTurn;
    if (r < 0) r += FullTurn;
    return r;
  endfunction

  function automatic longint turn_error(input longint tgt, input longint cur);
    longint e;
    e = tgt - cur;
    if (e > HalfTurn) e -= FullTurn;
    if (e < -HalfTurn) e += FullTurn;
    return e;
  endfunction

  function automatic longint effective_ms(input logic [15:0] elapsed);
    return (elapsed == 16'd0 || elapsed > 16'd500) ? 64'sd10 : longint'(elapsed);
  endfunction

  function automatic void reset_controller();
    cfg_turn_angle  = 18'd90000;
    cfg_tolerance   = 16'd3000;
    cfg_ramp_band   = 17'd20000;
    cfg_full_speed  = 8'd255;
    cfg_floor_speed = 8'd30;
    cfg_timeout     = 16'd3000;
    cfg_bias        = 16'sd500;
    track_yaw       = 0;
    track_target    = 0;
    track_timer     = 0;
    track_sense     = 1'b0;
    track_active    = 1'b0;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [17:0] value);
    case (idx)
      CfgTurnAngle: cfg_turn_angle  = value;
      CfgTolerance: cfg_tolerance   = value[15:0];
      CfgRampBand:  cfg_ramp_band   = value[16:0];
      CfgFullSpeed: cfg_full_speed  = value[7:0];
      CfgFloor:     cfg_floor_speed = value[7:0];
      CfgTimeout:   cfg_timeout     = value[15:0];
      CfgBias:      cfg_bias        = value[15:0];
      default: ;
    endcase
  endfunction

  function automatic motor_result_t advance_controller(input logic signed [15:0] gyro,
                                                       input logic [15:0] elapsed,
                                                       input logic start,
                                                       input logic positive);
    motor_result_t res;
    longint        rate4;
    longint        delta;
    longint        err;
    longint        aerr;
    longint        band;
    longint        duty;
    longint        t;
    rate4 = longint'(gyro) * 35 - longint'(cfg_bias) * 4;
    track_yaw = wrap_turn(track_yaw + rate4 * effective_ms(elapsed));
    if (track_active) begin
      t = track_timer + longint'(elapsed);
      track_timer = (t > TimerCap) ? TimerCap : t;
    end
    if (start && !track_active) begin
      delta = longint'(cfg_turn_angle) * FinePerMdegL;
      track_target = wrap_turn(track_yaw + (positive ? delta : -delta));
      track_sense = turn_error(track_target, track_yaw) >= 0;
      track_active = 1'b1;
      track_timer = 0;
    end
    res.cmd = CmdNone;
    res.speed = 8'd0;
    res.status = StatusIdle;
    if (track_active) begin
      err = turn_error(track_target, track_yaw);
      aerr = (err < 0) ? -err : err;
      if (aerr <= longint'(cfg_tolerance) * FinePerMdegL) begin
        res.cmd = CmdStop;
        res.status = StatusDone;
        track_active = 1'b0;
      end else if (track_timer > longint'(cfg_timeout)) begin
        res.cmd = CmdStop;
        res.status = StatusTimeout;
        track_active = 1'b0;
      end else begin
        band = longint'(cfg_ramp_band) * FinePerMdegL;
        duty = longint'(cfg_full_speed);
        if (band > 0 && aerr < band) begin
          duty = (longint'(cfg_full_speed) * aerr) / band;
          if (duty < longint'(cfg_floor_speed)) duty = longint'(cfg_floor_speed);
        end
        res.speed = duty[7:0];
        res.cmd = track_sense ? CmdRotUp : CmdRotDown;
        res.status = StatusTurning;
      end
    end
    res.yaw = 19'(track_yaw / FinePerMdegL);
    return res;
  endfunction

  function automatic logic [15:0] aimed_gyro(input logic [15:0] elapsed);
    longint err;
    longint g;
    err = turn_error(track_target, track_yaw);
    g = (err * longint'($urandom_range(30, 110)) / 100 / effective_ms(elapsed)
         + longint'(cfg_bias) * 4) / 35;
    if (g > 32767) g = 32767;
    if (g < -32768) g = -32768;
    return g[15:0];
  endfunction

  function automatic logic [15:0] pick_elapsed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 9) return 16'($urandom_range(501, 65535));
    return 16'($urandom_range(1, 500));
  endfunction

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic send_period(input logic signed [15:0] gyro, input logic [15:0] elapsed,
                             input logic start, input logic positive,
                             input logic typed, input motor_result_t typed_res);
    motor_result_t res;
    if (idling_on) begin
      if ($urandom_range(0, 9) == 0) begin
        s_axis_tvalid = 1'b0;
        wait_drained();
      end
      if ($urandom_range(0, 3) == 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'b0, positive, start, elapsed, gyro};
    do @(posedge clk_i); while (!s_axis_tready);
    res = advance_controller(gyro, elapsed, start, positive);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [17:0] value);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    store_reg(idx, value);
  endtask

  task automatic load_setting(input ctrl_setting_t s);
    write_reg(CfgTurnAngle, s.angle);
    write_reg(CfgTolerance, 18'(s.tol));
    write_reg(CfgRampBand, 18'(s.band));
    write_reg(CfgFullSpeed, 18'(s.full));
    write_reg(CfgFloor, 18'(s.floor));
    write_reg(CfgTimeout, 18'(s.timeout));
    write_reg(CfgBias, 18'(s.bias));
    cfg_we_i = 1'b0;
  endtask

  task automatic run_random(input int quota);
    int                 sent;
    int                 len;
    longint             mag;
    logic signed [15:0] g;
    logic [15:0]        el;
    logic               st;
    sent = 0;
    while (sent < quota) begin
      if ($urandom_range(0, 4) == 0) begin
        send_period(16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom), 1'b0, NoTyped);
        sent++;
      end else begin
        len = $urandom_range(2, 20);
        for (int i = 0; i < len && sent < quota && (i == 0 || track_active); i++) begin
          el = pick_elapsed();
          if (track_active && $urandom_range(0, 9) < 6) begin
            g = aimed_gyro(el);
          end else if (track_active && $urandom_range(0, 3) != 0) begin
            mag = longint'($urandom_range(500, 32767));
            g = 16'(track_sense ? mag : -mag);
          end else begin
            g = 16'($urandom);
          end
          st = (i == 0) || ($urandom_range(0, 7) == 0);
          send_period(g, el, st, 1'($urandom), 1'b0, NoTyped);
          sent++;
        end
      end
    end
  endtask

  initial begin
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!idling_on) begin
        m_axis_tready = 1'b1;
      end else if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready = 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    motor_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("motor result transfer with no pending expectation");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.cmd) begin
          $error("motor_cmd: expected %0d, got %0d", want.cmd, m_axis_tdata[1:0]);
          fail_count++;
        end
        if (m_axis_tdata[9:2] !== want.speed) begin
          $error("motor_speed: expected %0d, got %0d", want.speed, m_axis_tdata[9:2]);
          fail_count++;
        end
        if (m_axis_tdata[11:10] !== want.status) begin
          $error("turn_status: expected %0d, got %0d", want.status, m_axis_tdata[11:10]);
          fail_count++;
        end
        if (m_axis_tdata[30:12] !== want.yaw) begin
          $error("yaw_mdeg: expected %0d, got %0d", want.yaw, m_axis_tdata[30:12]);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CfgTurnAngle;
    cfg_wdata_i = '0;
    reset_controller();
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (DirectedRows[i]) begin
      send_period(DirectedRows[i].gyro, DirectedRows[i].elapsed, DirectedRows[i].start,
                  DirectedRows[i].positive, DirectedRows[i].typed, DirectedRows[i].res);
    end

    for (int p = 0; p < NumSettings; p++) begin
      s_axis_tvalid = 1'b0;
      wait_drained();
      idling_on = (p != NumSettings - 1);
      load_setting(Settings[p]);
      run_random(PhaseItems);
    end

    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
